[design/skf_pkg.sv]
// Shared constants, types and codes for the scalar Kalman filter unit.
// No dependencies; every other design file imports this package.
package skf_pkg;

    // default datapath format: signed Q16.16 in 32 bits
    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    // fixed field widths of the channels
    localparam int FIELD_WIDTH     = 32;
    localparam int DT_WIDTH        = 16;
    localparam int STD_WIDTH       = 24;
    localparam int GAIN_WIDTH      = 17;
    localparam int GAIN_FRAC       = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 24;

    // serial unit counters
    localparam int MUL_LEN_WIDTH = $clog2(STD_WIDTH + 1);
    localparam int DIV_CNT_WIDTH = $clog2(GAIN_WIDTH + 1);

    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1 << GAIN_FRAC);

    // register reset values
    localparam logic [DT_WIDTH-1:0]  SAMPLE_PERIOD_RESET = DT_WIDTH'(655);
    localparam logic [STD_WIDTH-1:0] NOISE_STD_RESET     = STD_WIDTH'(65536);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_SAMPLE_PERIOD     = 2'd0,
        CFG_MEAS_NOISE_STD    = 2'd1,
        CFG_PROCESS_NOISE_STD = 2'd2
    } skf_cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOISE,
        ST_PRED,
        ST_XP,
        ST_UPD,
        ST_WB
    } skf_state_t;

    // command to a serial multiplier
    typedef struct packed {
        logic                     start;
        logic [MUL_LEN_WIDTH-1:0] len;
    } skf_mul_cmd_t;

endpackage

[design/skf_sample_if.sv]
// Input channel: one sample word (first flag, measurement, jerk).
// Depends on skf_pkg.
interface skf_sample_if import skf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          first;
    logic signed [FIELD_WIDTH-1:0] measurement;
    logic signed [FIELD_WIDTH-1:0] jerk;

    modport source (output valid, first, measurement, jerk, input ready);
    modport sink   (input valid, first, measurement, jerk, output ready);
endinterface

[design/skf_result_if.sv]
// Output channel: one result word (estimate, gain, variance).
// Depends on skf_pkg.
interface skf_result_if import skf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_WIDTH-1:0] estimate;
    logic [GAIN_WIDTH-1:0]         gain;
    logic [FIELD_WIDTH-1:0]        variance;

    modport source (output valid, estimate, gain, variance, input ready);
    modport sink   (input valid, estimate, gain, variance, output ready);
endinterface

[design/skf_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on skf_pkg.
interface skf_cfg_if import skf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/skf_serial_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// Depends on skf_pkg (multiplier width, command struct).
module skf_serial_mul import skf_pkg::*; #(
    parameter int AW = DEF_DATA_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  skf_mul_cmd_t              cmd,
    input  logic [AW-1:0]             a,
    input  logic [STD_WIDTH-1:0]      b,      // left-aligned, top len bits used
    output logic [AW+STD_WIDTH-1:0]   product,
    output logic                      done
);
    localparam int PW = AW + STD_WIDTH;

    logic [MUL_LEN_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [AW-1:0]            a_reg, a_next;
    logic [STD_WIDTH-1:0]     b_reg, b_next;
    logic [PW-1:0]            acc_reg, acc_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            cnt_next = cmd.len;
            a_next   = a;
            b_next   = b;
            acc_next = {PW{1'b0}};
        end
        else if (cnt_reg != '0)
        begin
            acc_next  = {acc_reg[PW-2:0], 1'b0}
                      + (b_reg[STD_WIDTH-1] ? PW'(a_reg) : {PW{1'b0}});
            b_next    = {b_reg[STD_WIDTH-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == MUL_LEN_WIDTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

[design/skf_serial_div.sv]
// Restoring divider giving floor(num * 2^16 / den), one quotient bit a cycle.
// Depends on skf_pkg (gain width); needs num <= den and den != 0.
module skf_serial_div import skf_pkg::*; #(
    parameter int W = DEF_DATA_WIDTH + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [W-1:0]          num,
    input  logic [W-1:0]          den,
    output logic [GAIN_WIDTH-1:0] quot,
    output logic                  done
);
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [W:0]               rem_reg, rem_next;
    logic [W-1:0]             den_reg, den_next;
    logic [GAIN_WIDTH-1:0]    quot_reg, quot_next;
    logic                     ge;
    logic [W:0]               rem_sub;

    always_comb
    begin
        ge        = (rem_reg >= {1'b0, den_reg});
        rem_sub   = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = DIV_CNT_WIDTH'(GAIN_WIDTH);
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below den, so the shift loses nothing
            rem_next  = {rem_sub[W-1:0], 1'b0};
            quot_next = {quot_reg[GAIN_WIDTH-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

[design/scalar_kalman_filter_unit.sv]
// One-axis Kalman filter on fixed-point acceleration samples, one result word per sample word.
// Depends on skf_pkg, skf_sample_if, skf_result_if, skf_cfg_if, skf_serial_mul, skf_serial_div.
//
// A sample word with first set loads the estimate from the measurement and the
// variance from q, and its result (gain 0) is presented once write-back has
// loaded it into the result register. Any other word predicts x + jerk*dt and
// p + q, forms the gain p/(p+r) in a 17-step restoring divider, then corrects
// estimate and variance with two shift-add multipliers running 17 steps side by
// side; the divider and the 16-step jerk*dt multiply overlap, and samples.ready
// stays low from acceptance until such a word has left write-back. q and r are
// the squares of the noise registers and are rebuilt after reset and after
// every write to either noise register; while they are rebuilt no sample word
// is taken (writes are still taken). The result register lets the next sample
// word in while a result waits to be collected. Estimate and variance saturate
// to 32 bits.
module scalar_kalman_filter_unit import skf_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    skf_sample_if.sink   samples,
    skf_result_if.source results,
    skf_cfg_if.sink      cfg
);
    // multiplicand width, product width, extended signed width
    localparam int MA = (DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
    localparam int PW = MA + STD_WIDTH;
    localparam int EW = MA + 2;
    localparam int VW = MA + 1;

    localparam logic signed [EW-1:0] S_MAX = EW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] S_MIN = -S_MAX - EW'(1);
    localparam logic signed [EW-1:0] O_MAX = EW'(64'sd2147483647);
    localparam logic signed [EW-1:0] O_MIN = -O_MAX - EW'(1);

    // saturate an extended value to the signed data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [EW-1:0] x);
        logic signed [DATA_WIDTH-1:0] y;
        if (x > S_MAX)
            y = S_MAX[DATA_WIDTH-1:0];
        else if (x < S_MIN)
            y = S_MIN[DATA_WIDTH-1:0];
        else
            y = x[DATA_WIDTH-1:0];
        return y;
    endfunction

    // (std*std) >> FRAC_BITS, saturated to the unsigned data range
    function automatic logic [DATA_WIDTH-1:0] noise_sq(input logic [PW-1:0] prod);
        logic [PW-1:0] sh;
        sh = prod >> FRAC_BITS;
        return (|sh[PW-1:DATA_WIDTH]) ? {DATA_WIDTH{1'b1}} : sh[DATA_WIDTH-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [DT_WIDTH-1:0]  sample_period_reg;
    logic [STD_WIDTH-1:0] meas_std_reg;
    logic [STD_WIDTH-1:0] proc_std_reg;
    logic                 noise_wr;

    assign cfg.ready = 1'b1;
    assign noise_wr  = cfg.valid && (cfg.index == CFG_MEAS_NOISE_STD
                                  || cfg.index == CFG_PROCESS_NOISE_STD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= SAMPLE_PERIOD_RESET;
            meas_std_reg      <= NOISE_STD_RESET;
            proc_std_reg      <= NOISE_STD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SAMPLE_PERIOD:     sample_period_reg <= cfg.data[DT_WIDTH-1:0];
                CFG_MEAS_NOISE_STD:    meas_std_reg      <= cfg.data[STD_WIDTH-1:0];
                CFG_PROCESS_NOISE_STD: proc_std_reg      <= cfg.data[STD_WIDTH-1:0];
                default:               ; // unmapped index: dropped
            endcase
        end
    end

    // ---------------- control ----------------
    skf_state_t state_reg, state_next;
    logic       dirty_reg, dirty_next;       // q/r need rebuilding
    logic       out_valid_reg, out_valid_next;

    logic in_ready, noise_start, noise_done, first_load, pred_start, pred_done;
    logic upd_start, upd_done, wb_load;

    logic                     mul0_done, mul1_done, div_done;
    logic [PW-1:0]            prod0, prod1;
    logic [GAIN_WIDTH-1:0]    quot;
    skf_mul_cmd_t             mul0_cmd, mul1_cmd;
    logic [MA-1:0]            mul0_a, mul1_a;
    logic [STD_WIDTH-1:0]     mul0_b, mul1_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg)
                    state_next = ST_NOISE;
                else if (samples.valid)
                    state_next = samples.first ? ST_WB : ST_PRED;
            end
            ST_NOISE: if (mul0_done) state_next = ST_IDLE;
            ST_PRED:  if (div_done)  state_next = ST_XP;
            ST_XP:    state_next = ST_UPD;
            ST_UPD:   if (mul0_done && mul1_done) state_next = ST_WB;
            ST_WB:    if (!out_valid_reg || results.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        in_ready    = 1'b0;
        noise_start = 1'b0;
        noise_done  = 1'b0;
        first_load  = 1'b0;
        pred_start  = 1'b0;
        pred_done   = 1'b0;
        upd_start   = 1'b0;
        upd_done    = 1'b0;
        wb_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = !dirty_reg;
                noise_start = dirty_reg;
                first_load  = !dirty_reg && samples.valid && samples.first;
                pred_start  = !dirty_reg && samples.valid && !samples.first;
            end
            ST_NOISE: noise_done = mul0_done;
            ST_PRED:  pred_done  = div_done;
            ST_XP:    upd_start  = 1'b1;
            ST_UPD:   upd_done   = mul0_done && mul1_done;
            ST_WB:    wb_load    = !out_valid_reg || results.ready;
            default:  ;
        endcase
    end

    assign dirty_next     = noise_wr || (dirty_reg && !noise_start);
    assign out_valid_next = wb_load || (out_valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b1;          // build q/r once after reset
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign samples.ready = in_ready;

    // ---------------- filter state and datapath ----------------
    logic signed [DATA_WIDTH-1:0] est_reg;
    logic [DATA_WIDTH-1:0]        var_reg;
    logic [DATA_WIDTH-1:0]        q_reg, r_reg;
    logic [DATA_WIDTH-1:0]        pp_reg;
    logic                         s_zero_reg;
    logic signed [DATA_WIDTH-1:0] meas_reg, xp_reg;
    logic                         jerk_neg_reg, d_neg_reg;
    logic [GAIN_WIDTH-1:0]        gain_reg;

    logic signed [EW-1:0]    meas_ext;
    logic [FIELD_WIDTH-1:0]  jerk_mag;
    logic [DATA_WIDTH:0]     pp_sum, s_sum;
    logic [DATA_WIDTH-1:0]   pp_c;
    logic signed [EW-1:0]    jd_ext, jd_s, xp_sum;
    logic signed [EW-1:0]    d_full;
    logic [EW-1:0]           d_abs;
    logic signed [EW-1:0]    corr_ext, est_sum;
    logic [DATA_WIDTH:0]     var_sh;
    logic [GAIN_WIDTH-1:0]   gain_c, one_minus_gain;

    always_comb
    begin
        meas_ext = EW'(samples.measurement);
        jerk_mag = samples.jerk[FIELD_WIDTH-1] ? (~samples.jerk + 1'b1) : samples.jerk;

        // predicted variance and gain denominator
        pp_sum = {1'b0, var_reg} + {1'b0, q_reg};
        pp_c   = pp_sum[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : pp_sum[DATA_WIDTH-1:0];
        s_sum  = {1'b0, pp_c} + {1'b0, r_reg};

        // x + jerk*dt, jerk*dt truncated toward zero
        jd_ext = {{(EW - FIELD_WIDTH){1'b0}}, prod0[GAIN_FRAC +: FIELD_WIDTH]};
        jd_s   = jerk_neg_reg ? -jd_ext : jd_ext;
        xp_sum = EW'(est_reg) + jd_s;
        gain_c = s_zero_reg ? '0 : quot;

        // innovation
        d_full         = EW'(meas_reg) - EW'(xp_reg);
        d_abs          = d_full[EW-1] ? -d_full : d_full;
        one_minus_gain = GAIN_ONE - gain_reg;

        // correction k*(z - x'), truncated toward zero
        corr_ext = {1'b0, prod0[GAIN_FRAC +: (EW - 1)]};
        est_sum  = EW'(xp_reg) + (d_neg_reg ? -corr_ext : corr_ext);
        var_sh   = prod1[GAIN_FRAC +: (DATA_WIDTH + 1)];
    end

    // multiplier operand selection
    always_comb
    begin
        mul0_cmd.start = noise_start || pred_start || upd_start;
        mul1_cmd.start = noise_start || upd_start;
        if (noise_start)
        begin
            mul0_cmd.len = MUL_LEN_WIDTH'(STD_WIDTH);
            mul1_cmd.len = MUL_LEN_WIDTH'(STD_WIDTH);
            mul0_a       = MA'(proc_std_reg);
            mul0_b       = proc_std_reg;
            mul1_a       = MA'(meas_std_reg);
            mul1_b       = meas_std_reg;
        end
        else if (pred_start)
        begin
            mul0_cmd.len = MUL_LEN_WIDTH'(DT_WIDTH);
            mul1_cmd.len = MUL_LEN_WIDTH'(GAIN_WIDTH);
            mul0_a       = MA'(jerk_mag);
            mul0_b       = {sample_period_reg, {(STD_WIDTH - DT_WIDTH){1'b0}}};
            mul1_a       = MA'(pp_reg);
            mul1_b       = {one_minus_gain, {(STD_WIDTH - GAIN_WIDTH){1'b0}}};
        end
        else
        begin
            mul0_cmd.len = MUL_LEN_WIDTH'(GAIN_WIDTH);
            mul1_cmd.len = MUL_LEN_WIDTH'(GAIN_WIDTH);
            mul0_a       = d_abs[MA-1:0];
            mul0_b       = {gain_reg, {(STD_WIDTH - GAIN_WIDTH){1'b0}}};
            mul1_a       = MA'(pp_reg);
            mul1_b       = {one_minus_gain, {(STD_WIDTH - GAIN_WIDTH){1'b0}}};
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= '0;
            var_reg <= '0;
        end
        else if (first_load)
        begin
            est_reg <= sat_data(meas_ext);
            var_reg <= q_reg;
        end
        else if (upd_done)
        begin
            est_reg <= sat_data(est_sum);
            var_reg <= var_sh[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : var_sh[DATA_WIDTH-1:0];
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (noise_done)
        begin
            q_reg <= noise_sq(prod0);
            r_reg <= noise_sq(prod1);
        end
        if (pred_start)
        begin
            meas_reg     <= sat_data(meas_ext);
            jerk_neg_reg <= samples.jerk[FIELD_WIDTH-1];
            pp_reg       <= pp_c;
            s_zero_reg   <= (s_sum == '0);
        end
        if (first_load)
            gain_reg <= '0;
        else if (pred_done)
            gain_reg <= gain_c;
        if (pred_done)
            xp_reg <= sat_data(xp_sum);
        if (upd_start)
            d_neg_reg <= d_full[EW-1];
    end

    skf_serial_mul #(.AW(MA)) u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul0_cmd),
        .a       (mul0_a),
        .b       (mul0_b),
        .product (prod0),
        .done    (mul0_done)
    );

    skf_serial_mul #(.AW(MA)) u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul1_cmd),
        .a       (mul1_a),
        .b       (mul1_b),
        .product (prod1),
        .done    (mul1_done)
    );

    skf_serial_div #(.W(DATA_WIDTH + 1)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pred_start),
        .num   ({1'b0, pp_c}),
        .den   (s_sum),
        .quot  (quot),
        .done  (div_done)
    );

    // ---------------- result register ----------------
    logic signed [EW-1:0]    est_ext;
    logic [VW-1:0]           var_ext;
    logic [FIELD_WIDTH-1:0]  est_out, var_out;
    logic signed [FIELD_WIDTH-1:0] estimate_reg;
    logic [GAIN_WIDTH-1:0]   gain_out_reg;
    logic [FIELD_WIDTH-1:0]  variance_reg;

    always_comb
    begin
        est_ext = EW'(est_reg);
        var_ext = VW'(var_reg);
        if (est_ext > O_MAX)
            est_out = O_MAX[FIELD_WIDTH-1:0];
        else if (est_ext < O_MIN)
            est_out = O_MIN[FIELD_WIDTH-1:0];
        else
            est_out = est_ext[FIELD_WIDTH-1:0];
        var_out = (|var_ext[VW-1:FIELD_WIDTH]) ? {FIELD_WIDTH{1'b1}}
                                               : var_ext[FIELD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wb_load)
        begin
            estimate_reg <= est_out;
            gain_out_reg <= gain_reg;
            variance_reg <= var_out;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.estimate = estimate_reg;
    assign results.gain     = gain_out_reg;
    assign results.variance = variance_reg;

    // ---------------- assertions ----------------
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.gain <= GAIN_ONE)
        else $error("gain above one");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_PRED)
        else $error("divider finished outside prediction");

    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul0_done |-> (state_reg == ST_NOISE || state_reg == ST_PRED
                    || state_reg == ST_UPD))
        else $error("multiplier finished with nobody waiting");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready && samples.first)
            |=> (gain_reg == '0 && state_reg == ST_WB))
        else $error("first word did not go straight to write-back");

    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WB))
        else $error("result raised outside write-back");

endmodule

[tb/sv/tb_scalar_kalman_filter_unit.sv]
// Self-checking bench for scalar_kalman_filter_unit: sample, result and register channels.
// Depends on skf_pkg, skf_sample_if, skf_result_if, skf_cfg_if and the unit itself.
// A bit-exact filter tracker in the bench predicts each result word.
module tb_scalar_kalman_filter_unit;
    import skf_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 108;
    localparam int SMALL_SPAN   = 1 << 20;     // small signed values, about +/-16.0
    localparam int END_WAIT     = 60;          // cycles after the last result word
    localparam int STALL_LIMIT  = 3000;        // cycles with no word moving on any channel

    // register index with no register behind it: writes must be dropped
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INDEX_SPARE = 2'd3;

    localparam logic signed [FIELD_WIDTH-1:0] FIELD_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
    localparam logic signed [FIELD_WIDTH-1:0] FIELD_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
    localparam logic [STD_WIDTH-1:0]          STD_MAX   = {STD_WIDTH{1'b1}};
    localparam logic [DT_WIDTH-1:0]           DT_MAX    = {DT_WIDTH{1'b1}};

    localparam longint    EST_MAX = (longint'(1) << (FIELD_WIDTH - 1)) - 1;
    localparam longint    EST_MIN = -EST_MAX - 1;
    localparam bit [63:0] VAR_MAX = (64'd1 << FIELD_WIDTH) - 1;

    // receiver stall styles
    typedef enum {RX_ALWAYS, RX_CHOPPY, RX_LONG_STALLS} rx_style_t;

    // one result word as the unit should present it
    typedef struct {
        logic signed [FIELD_WIDTH-1:0] estimate;
        logic [GAIN_WIDTH-1:0]         gain;
        logic [FIELD_WIDTH-1:0]        variance;
    } filter_word_t;

    // ------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    skf_sample_if sample_ch();
    skf_result_if result_ch();
    skf_cfg_if    cfg_ch();

    scalar_kalman_filter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Filter tracker: register copies and filter state
    // ------------------------------------------------------------------
    logic [DT_WIDTH-1:0]  dt_q16;
    logic [STD_WIDTH-1:0] meas_std;
    logic [STD_WIDTH-1:0] proc_std;
    longint               track_estimate;
    bit [63:0]            track_variance;

    filter_word_t estimates_due[$];
    int           mismatches;

    // sender and receiver idling knobs
    int        tx_max_gap;
    int        tx_max_burst;
    int        tx_burst_left;
    rx_style_t rx_style;

    function automatic longint clamp_est(longint v);
        if (v > EST_MAX)
            return EST_MAX;
        if (v < EST_MIN)
            return EST_MIN;
        return v;
    endfunction

    function automatic bit [63:0] clamp_var(bit [63:0] v);
        return (v > VAR_MAX) ? VAR_MAX : v;
    endfunction

    // floor(a * g / 2^16), split so the product cannot overflow
    function automatic bit [63:0] scale_q16(bit [63:0] a, bit [63:0] g);
        return (a >> 16) * g + (((a & 64'hFFFF) * g) >> 16);
    endfunction

    // signed value by unsigned Q0.16/Q1.16 factor, truncated toward zero
    function automatic longint scale_signed_q16(longint a, bit [63:0] g);
        bit [63:0] mag;
        bit [63:0] prod;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = scale_q16(mag, g);
        return (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // q or r: std squared, back to Q16.16, clipped to the field
    function automatic bit [63:0] noise_power(logic [STD_WIDTH-1:0] std_v);
        return clamp_var((64'(std_v) * 64'(std_v)) >> DEF_FRAC_BITS);
    endfunction

    // gain = floor(p * 2^16 / s), bit-serial as the hardware does it
    function automatic bit [63:0] gain_quotient(bit [63:0] num, bit [63:0] den);
        bit [63:0] rem;
        bit [63:0] quo;
        rem = num;
        quo = '0;
        for (int i = 0; i < GAIN_WIDTH; i++)
        begin
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
            rem = rem << 1;
        end
        return quo;
    endfunction

    task automatic reset_tracker();
        dt_q16         = SAMPLE_PERIOD_RESET;
        meas_std       = NOISE_STD_RESET;
        proc_std       = NOISE_STD_RESET;
        track_estimate = 0;
        track_variance = '0;
    endtask

    // One filter step on an accepted sample word; updates the tracked state.
    function automatic filter_word_t kalman_step_estimate(
        logic first_flag,
        logic signed [FIELD_WIDTH-1:0] meas_in,
        logic signed [FIELD_WIDTH-1:0] jerk_in
    );
        filter_word_t word;
        longint       meas;
        longint       jerk;
        longint       x_pred;
        bit [63:0]    q;
        bit [63:0]    r;
        bit [63:0]    p_pred;
        bit [63:0]    k;
        meas = meas_in;
        jerk = jerk_in;
        q    = noise_power(proc_std);
        r    = noise_power(meas_std);
        k    = '0;
        if (first_flag)
        begin
            track_estimate = meas;
            track_variance = q;
        end
        else
        begin
            x_pred = clamp_est(track_estimate + scale_signed_q16(jerk, 64'(dt_q16)));
            p_pred = clamp_var(track_variance + q);
            // p'+r of zero: gain stays 0, estimate stays at the prediction
            if (p_pred + r != 0)
                k = gain_quotient(p_pred, p_pred + r);
            track_estimate = clamp_est(x_pred + scale_signed_q16(meas - x_pred, k));
            track_variance = clamp_var(scale_q16(p_pred, 64'(GAIN_ONE) - k));
        end
        word.estimate = track_estimate[FIELD_WIDTH-1:0];
        word.gain     = k[GAIN_WIDTH-1:0];
        word.variance = track_variance[FIELD_WIDTH-1:0];
        return word;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: every channel sampled at the rising edge. Result words are
    // checked before a sample word on the same edge is predicted, although
    // the two can never belong together.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        filter_word_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (estimates_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected (est %0d gain %0d var %0d)",
                             $time, result_ch.estimate, result_ch.gain, result_ch.variance);
                end
                else
                begin
                    want = estimates_due.pop_front();
                    if (want.estimate !== result_ch.estimate)
                    begin
                        mismatches++;
                        $display("%0t: estimate expected %0d got %0d",
                                 $time, want.estimate, result_ch.estimate);
                    end
                    if (want.gain !== result_ch.gain)
                    begin
                        mismatches++;
                        $display("%0t: gain expected %0d got %0d",
                                 $time, want.gain, result_ch.gain);
                    end
                    if (want.variance !== result_ch.variance)
                    begin
                        mismatches++;
                        $display("%0t: variance expected %0d got %0d",
                                 $time, want.variance, result_ch.variance);
                    end
                end
            end

            if (sample_ch.valid && sample_ch.ready)
                estimates_due.insert(estimates_due.size(),
                                     kalman_step_estimate(sample_ch.first,
                                                          sample_ch.measurement,
                                                          sample_ch.jerk));

            // register writes land only while no sample word is in the unit
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_SAMPLE_PERIOD:     dt_q16   = cfg_ch.data[DT_WIDTH-1:0];
                    CFG_MEAS_NOISE_STD:    meas_std = cfg_ch.data[STD_WIDTH-1:0];
                    CFG_PROCESS_NOISE_STD: proc_std = cfg_ch.data[STD_WIDTH-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on any channel for too long
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_scalar_kalman_filter_unit NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern of its own, changed at the falling edge
    // ------------------------------------------------------------------
    initial
    begin
        int   run_left;
        logic level;
        run_left        = 0;
        level           = 1'b1;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            case (rx_style)
                RX_ALWAYS: level = 1'b1;
                RX_CHOPPY: level = ($urandom_range(0, 2) != 0);
                default:
                begin
                    // alternate runs: short open windows, longer stalls
                    if (run_left == 0)
                    begin
                        level    = !level;
                        run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 60);
                    end
                    run_left--;
                end
            endcase
            result_ch.ready <= level;
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------
    task automatic set_idling(int max_gap, int max_burst, rx_style_t style);
        tx_max_gap    = max_gap;
        tx_max_burst  = max_burst;
        tx_burst_left = 0;
        rx_style      = style;
    endtask

    // Offer one sample word and hold it until taken. Valid stays high on
    // return so a burst runs back to back; a random gap, which may be empty, comes between bursts.
    task automatic send_sample(
        input logic                          first_flag,
        input logic signed [FIELD_WIDTH-1:0] meas,
        input logic signed [FIELD_WIDTH-1:0] jerk_v
    );
        int gap;
        @(negedge clk);
        if (tx_burst_left == 0)
        begin
            gap           = $urandom_range(0, tx_max_gap);
            tx_burst_left = $urandom_range(1, tx_max_burst);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        tx_burst_left--;
        sample_ch.valid       <= 1'b1;
        sample_ch.first       <= first_flag;
        sample_ch.measurement <= meas;
        sample_ch.jerk        <= jerk_v;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Sender goes quiet until every outstanding result word has been checked.
    task automatic drain_results();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        tx_burst_left    = 0;
        while (estimates_due.size() != 0)
            @(negedge clk);
    endtask

    // Register write; only called once drained, so no sample word is in the unit.
    task automatic write_reg(
        input logic [CFG_INDEX_WIDTH-1:0] idx,
        input logic [CFG_DATA_WIDTH-1:0]  value
    );
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mix of extremes, full-range and small signed Q16.16 values
    function automatic logic signed [FIELD_WIDTH-1:0] rand_field();
        case ($urandom_range(0, 9))
            0:       return FIELD_MAX;
            1:       return FIELD_MIN;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return $urandom;
            default: return int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
        endcase
    endfunction

    function automatic logic [STD_WIDTH-1:0] pick_std();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return STD_MAX;
            2:       return NOISE_STD_RESET;
            3, 4, 5: return STD_WIDTH'($urandom_range(1 << 10, 1 << 18));
            default: return STD_WIDTH'($urandom_range(0, STD_MAX));
        endcase
    endfunction

    function automatic logic [DT_WIDTH-1:0] pick_dt();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return DT_MAX;
            2:       return SAMPLE_PERIOD_RESET;
            3, 4:    return DT_WIDTH'($urandom_range(1, 4000));
            default: return DT_WIDTH'($urandom_range(0, DT_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values of the registers; steps before any first sample run
    // from the cleared state.
    task automatic test_before_first_sample();
        set_idling(2, 4, RX_CHOPPY);
        send_sample(1'b0, 32'sd100000, 32'sd65536);
        send_sample(1'b0, -32'sd300000, '0);
        send_sample(1'b1, 32'sd5 <<< 16, '0);
        send_sample(1'b0, 32'sd6 <<< 16, 32'sd1 <<< 16);
        send_sample(1'b0, 32'sd4 <<< 16, -(32'sd1 <<< 16));
    endtask

    // Field extremes, prediction overflow with the longest and zero dt
    task automatic test_field_extremes();
        set_idling(0, 1, RX_ALWAYS);
        send_sample(1'b1, FIELD_MAX, '0);
        send_sample(1'b0, FIELD_MIN, FIELD_MAX);
        send_sample(1'b0, '1, FIELD_MIN);
        drain_results();
        write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_WIDTH'(DT_MAX));
        send_sample(1'b0, FIELD_MAX, FIELD_MAX);
        send_sample(1'b0, FIELD_MAX, FIELD_MAX);
        send_sample(1'b1, FIELD_MIN, '0);
        send_sample(1'b0, FIELD_MIN, FIELD_MIN);
        drain_results();
        write_reg(CFG_SAMPLE_PERIOD, '0);
        send_sample(1'b0, '0, FIELD_MAX);
    endtask

    // Largest noise (variance sum clips), zero noise (zero denominator),
    // zero measurement noise (full gain), write to the spare index.
    task automatic test_noise_extremes();
        set_idling(5, 3, RX_LONG_STALLS);
        drain_results();
        write_reg(CFG_MEAS_NOISE_STD, STD_MAX);
        write_reg(CFG_PROCESS_NOISE_STD, STD_MAX);
        send_sample(1'b1, '0, '0);
        send_sample(1'b0, FIELD_MAX, '0);
        send_sample(1'b0, FIELD_MIN, '0);
        drain_results();
        write_reg(CFG_MEAS_NOISE_STD, '0);
        write_reg(CFG_PROCESS_NOISE_STD, '0);
        send_sample(1'b1, 32'sd1 <<< 16, '0);
        send_sample(1'b0, 32'sd2 <<< 16, 32'sd1 <<< 16);
        drain_results();
        write_reg(CFG_PROCESS_NOISE_STD, CFG_DATA_WIDTH'(1 << 16));
        send_sample(1'b0, 32'sd3 <<< 16, '0);
        drain_results();
        write_reg(CFG_INDEX_SPARE, CFG_DATA_WIDTH'($urandom));
        send_sample(1'b0, 32'sd7 <<< 16, '0);
        drain_results();
        write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_WIDTH'(SAMPLE_PERIOD_RESET));
        write_reg(CFG_MEAS_NOISE_STD, NOISE_STD_RESET);
        write_reg(CFG_PROCESS_NOISE_STD, NOISE_STD_RESET);
    endtask

    // Phases of random settings; within each, mostly tracking runs that
    // open with a first word and follow a slowly moving signal, plus stray
    // words and runs with no opening first word.
    task automatic test_random_filtering();
        int     sent;
        int     run_len;
        longint truth;
        longint drift;
        logic signed [FIELD_WIDTH-1:0] jerk_v;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_results();
            case (phase % 4)
                0:       set_idling(0, 1, RX_ALWAYS);
                1:       set_idling(3, 8, RX_CHOPPY);
                2:       set_idling(50, 3, RX_LONG_STALLS);
                default: set_idling($urandom_range(0, 20), $urandom_range(1, 16),
                                    rx_style_t'($urandom_range(0, 2)));
            endcase
            // spare upper bits on the dt write must be ignored
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_SAMPLE_PERIOD, {8'($urandom), pick_dt()});
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_MEAS_NOISE_STD, pick_std());
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_PROCESS_NOISE_STD, pick_std());

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                run_len = $urandom_range(1, 30);
                truth   = int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN;
                drift   = int'($urandom_range(0, 4096)) - 2048;
                if ($urandom_range(0, 9) != 0)
                begin
                    send_sample(1'b1, truth[FIELD_WIDTH-1:0], '0);
                    sent++;
                end
                for (int k = 0; k < run_len; k++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_sample(1'($urandom_range(0, 1)), rand_field(), rand_field());
                    else
                    begin
                        jerk_v = ($urandom_range(0, 7) == 0) ? rand_field()
                                                             : FIELD_WIDTH'(drift <<< 4);
                        send_sample(1'b0,
                                    FIELD_WIDTH'(clamp_est(truth
                                        + int'($urandom_range(0, 65536)) - 32768)),
                                    jerk_v);
                    end
                    truth = clamp_est(truth + drift);
                    sent++;
                end
                // now and then let everything settle before carrying on
                if ($urandom_range(0, 40) == 0)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.first       = 1'b0;
        sample_ch.measurement = '0;
        sample_ch.jerk        = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_SAMPLE_PERIOD;
        cfg_ch.data           = '0;
        mismatches            = 0;
        set_idling(0, 1, RX_ALWAYS);
        reset_tracker();

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_before_first_sample();
        test_field_extremes();
        test_noise_extremes();
        test_random_filtering();

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0 && estimates_due.size() == 0)
            $display("tb_scalar_kalman_filter_unit OK");
        else
            $display("tb_scalar_kalman_filter_unit NOT OK");
        $finish;
    end

endmodule
